// ----- rtl/core/cphb_pkg.sv -----
package cphb_pkg;

   localparam int COLOR_W            = 24;
   localparam int INDEX_W            = 8;
   localparam int COUNT_W            = 9;
   localparam int HASH_W             = 12;
   localparam int TABLE_DEPTH        = 4096;
   localparam int LIST_DEPTH         = 256;
   localparam int MAX_COLORS_DEFAULT = 256;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_FIND   = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STATUS_DONE      = 3'd0,
      STATUS_ADDED     = 3'd1,
      STATUS_PRESENT   = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_PROBE,
      ST_LIST
   } state_type;

   typedef struct packed {
      func_type             func;
      logic [COLOR_W-1:0]   pixel_color;
      logic [INDEX_W-1:0]   palette_slot;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [INDEX_W-1:0]   color_index;
      logic [COLOR_W-1:0]   slot_color;
      logic [COUNT_W-1:0]   color_count;
      logic                 overflowed;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic [INDEX_W-1:0]   index;
      logic [COLOR_W-1:0]   color;
   } bucket_type;

   localparam int BUCKET_W = $bits(bucket_type);

   typedef struct packed {
      logic                 wr_en;
      logic [HASH_W-1:0]    wr_addr;
      bucket_type           wr_data;
      logic [HASH_W-1:0]    rd_addr;
   } bkt_port_type;

   typedef struct packed {
      logic                 wr_en;
      logic [INDEX_W-1:0]   wr_addr;
      logic [COLOR_W-1:0]   wr_data;
      logic [INDEX_W-1:0]   rd_addr;
   } lst_port_type;

endpackage

// ----- rtl/core/cphb_ram.sv -----
module cphb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/cphb_ctrl.sv -----
module cphb_ctrl #(
   parameter int MAX_COLORS = cphb_pkg::MAX_COLORS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  cphb_pkg::req_type              req_data,
   output logic                           rsp_strobe,
   output cphb_pkg::rsp_type              rsp_data,
   output cphb_pkg::bkt_port_type         bkt,
   input  logic [cphb_pkg::BUCKET_W-1:0]  bkt_rd_data,
   output cphb_pkg::lst_port_type         lst,
   input  logic [cphb_pkg::COLOR_W-1:0]   lst_rd_data
);

   localparam logic [cphb_pkg::COUNT_W-1:0] MaxCount = cphb_pkg::COUNT_W'(MAX_COLORS);

   cphb_pkg::state_type                state_ff, state_in;
   logic [cphb_pkg::HASH_W-1:0]        h_ff, h_in;
   logic [cphb_pkg::HASH_W-1:0]        steps_ff, steps_in;
   logic [cphb_pkg::HASH_W-1:0]        clr_ff, clr_in;
   logic                               clr_rsp_ff, clr_rsp_in;
   logic [cphb_pkg::COLOR_W-1:0]       color_ff, color_in;
   cphb_pkg::func_type                 func_ff, func_in;
   logic [cphb_pkg::INDEX_W-1:0]       slot_ff, slot_in;
   logic [cphb_pkg::COUNT_W-1:0]       size_ff, size_in;
   logic                               ovf_ff, ovf_in;
   logic                               rsp_strobe_ff, rsp_strobe_in;
   cphb_pkg::rsp_type                  rsp_ff, rsp_in;

   cphb_pkg::bucket_type               bucket;
   logic [cphb_pkg::HASH_W-1:0]        req_hash;
   logic                               probe_empty;
   logic                               probe_hit;
   logic                               probe_last;
   logic                               probe_done;
   logic                               has_room;

   assign bucket      = cphb_pkg::bucket_type'(bkt_rd_data);
   assign req_hash    = req_data.pixel_color[2*cphb_pkg::HASH_W-1:cphb_pkg::HASH_W]
                        ^ req_data.pixel_color[cphb_pkg::HASH_W-1:0];
   assign probe_empty = !bucket.valid;
   assign probe_hit   = bucket.valid && (bucket.color == color_ff);
   assign probe_last  = (steps_ff == '1);
   assign probe_done  = probe_empty || probe_hit || probe_last;
   assign has_room    = (size_ff < MaxCount);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cphb_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_data.func)
                  cphb_pkg::FUNC_CLEAR:  state_in = cphb_pkg::ST_CLEAR;
                  cphb_pkg::FUNC_INSERT: state_in = cphb_pkg::ST_PROBE;
                  cphb_pkg::FUNC_FIND:   state_in = cphb_pkg::ST_PROBE;
                  cphb_pkg::FUNC_READ:   state_in = cphb_pkg::ST_LIST;
                  default:               state_in = cphb_pkg::ST_IDLE;
               endcase
            end
         end
         cphb_pkg::ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = cphb_pkg::ST_IDLE;
            end
         end
         cphb_pkg::ST_PROBE: begin
            if (probe_done) begin
               state_in = cphb_pkg::ST_IDLE;
            end
         end
         cphb_pkg::ST_LIST: state_in = cphb_pkg::ST_IDLE;
         default:           state_in = cphb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      bkt.wr_en    = 1'b0;
      bkt.wr_addr  = clr_ff;
      bkt.wr_data  = '0;
      bkt.rd_addr  = h_ff + cphb_pkg::HASH_W'(1);
      lst.wr_en    = 1'b0;
      lst.wr_addr  = size_ff[cphb_pkg::INDEX_W-1:0];
      lst.wr_data  = color_ff;
      lst.rd_addr  = req_data.palette_slot;
      h_in         = h_ff;
      steps_in     = steps_ff;
      clr_in       = clr_ff;
      clr_rsp_in   = clr_rsp_ff;
      color_in     = color_ff;
      func_in      = func_ff;
      slot_in      = slot_ff;
      size_in      = size_ff;
      ovf_in       = ovf_ff;
      rsp_strobe_in = 1'b0;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         cphb_pkg::ST_IDLE: begin
            bkt.rd_addr = req_hash;
            if (start) begin
               color_in = req_data.pixel_color;
               func_in  = req_data.func;
               slot_in  = req_data.palette_slot;
               h_in     = req_hash;
               steps_in = '0;
               if (req_data.func == cphb_pkg::FUNC_CLEAR) begin
                  size_in    = '0;
                  ovf_in     = 1'b0;
                  clr_in     = '0;
                  clr_rsp_in = 1'b1;
               end
            end
         end
         cphb_pkg::ST_CLEAR: begin
            bkt.wr_en = 1'b1;
            clr_in    = clr_ff + cphb_pkg::HASH_W'(1);
            if (clr_ff == '1 && clr_rsp_ff) begin
               clr_rsp_in         = 1'b0;
               rsp_strobe_in      = 1'b1;
               rsp_in.status      = cphb_pkg::STATUS_DONE;
               rsp_in.color_index = '0;
               rsp_in.slot_color  = '0;
               rsp_in.color_count = size_ff;
               rsp_in.overflowed  = ovf_ff;
            end
         end
         cphb_pkg::ST_PROBE: begin
            rsp_in.color_index = '0;
            rsp_in.slot_color  = '0;
            rsp_in.color_count = size_ff;
            rsp_in.overflowed  = ovf_ff;
            rsp_in.status      = cphb_pkg::STATUS_NOT_FOUND;
            if (probe_hit) begin
               rsp_strobe_in      = 1'b1;
               rsp_in.status      = cphb_pkg::STATUS_PRESENT;
               rsp_in.color_index = bucket.index;
            end else if (probe_empty || probe_last) begin
               rsp_strobe_in = 1'b1;
               if (func_ff == cphb_pkg::FUNC_INSERT) begin
                  if (probe_empty && has_room) begin
                     bkt.wr_en            = 1'b1;
                     bkt.wr_addr          = h_ff;
                     bkt.wr_data.valid    = 1'b1;
                     bkt.wr_data.index    = size_ff[cphb_pkg::INDEX_W-1:0];
                     bkt.wr_data.color    = color_ff;
                     lst.wr_en            = 1'b1;
                     size_in              = size_ff + cphb_pkg::COUNT_W'(1);
                     rsp_in.status        = cphb_pkg::STATUS_ADDED;
                     rsp_in.color_index   = size_ff[cphb_pkg::INDEX_W-1:0];
                     rsp_in.color_count   = size_ff + cphb_pkg::COUNT_W'(1);
                  end else begin
                     ovf_in             = 1'b1;
                     rsp_in.status      = cphb_pkg::STATUS_FULL;
                     rsp_in.overflowed  = 1'b1;
                  end
               end
            end else begin
               h_in     = h_ff + cphb_pkg::HASH_W'(1);
               steps_in = steps_ff + cphb_pkg::HASH_W'(1);
            end
         end
         cphb_pkg::ST_LIST: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.color_index = '0;
            rsp_in.color_count = size_ff;
            rsp_in.overflowed  = ovf_ff;
            if (cphb_pkg::COUNT_W'(slot_ff) < size_ff) begin
               rsp_in.status     = cphb_pkg::STATUS_DONE;
               rsp_in.slot_color = lst_rd_data;
            end else begin
               rsp_in.status     = cphb_pkg::STATUS_NOT_FOUND;
               rsp_in.slot_color = '0;
            end
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cphb_pkg::ST_CLEAR;
         clr_ff        <= '0;
         clr_rsp_ff    <= 1'b0;
         size_ff       <= '0;
         ovf_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         clr_rsp_ff    <= clr_rsp_in;
         size_ff       <= size_in;
         ovf_ff        <= ovf_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff     <= h_in;
      steps_ff <= steps_in;
      color_ff <= color_in;
      func_ff  <= func_in;
      slot_ff  <= slot_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != cphb_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- rtl/core/color_palette_hash_builder_core.sv -----
// insert/find: result strobe is registered after the last bucket probed
// (one bucket table read per cycle); next start taken in the cycle of the result strobe
// read palette color: list RAM read, then registered result; next start taken with the result
// clear: sweep of all 4096 buckets of the table, one bucket per cycle, then result
// reset: same sweep with busy high and no result; results cannot stall
module color_palette_hash_builder_core #(
   parameter int MAX_COLORS = cphb_pkg::MAX_COLORS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  cphb_pkg::req_type  req_data,
   output logic               rsp_strobe,
   output cphb_pkg::rsp_type  rsp_data
);

   cphb_pkg::bkt_port_type            bkt;
   cphb_pkg::lst_port_type            lst;
   logic [cphb_pkg::BUCKET_W-1:0]     bkt_rd_data;
   logic [cphb_pkg::COLOR_W-1:0]      lst_rd_data;

   cphb_ctrl #(
      .MAX_COLORS (MAX_COLORS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .bkt         (bkt),
      .bkt_rd_data (bkt_rd_data),
      .lst         (lst),
      .lst_rd_data (lst_rd_data)
   );

   cphb_ram #(
      .WIDTH (cphb_pkg::BUCKET_W),
      .DEPTH (cphb_pkg::TABLE_DEPTH)
   ) u_bucket_ram (
      .clock   (clock),
      .wr_en   (bkt.wr_en),
      .wr_addr (bkt.wr_addr),
      .wr_data (bkt.wr_data),
      .rd_addr (bkt.rd_addr),
      .rd_data (bkt_rd_data)
   );

   cphb_ram #(
      .WIDTH (cphb_pkg::COLOR_W),
      .DEPTH (cphb_pkg::LIST_DEPTH)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (lst.wr_en),
      .wr_addr (lst.wr_addr),
      .wr_data (lst.wr_data),
      .rd_addr (lst.rd_addr),
      .rd_data (lst_rd_data)
   );

endmodule
